/* rtl/sample_aggregation_hash_log_assert.svh */
// ----------------------------------------------------------------------------
// sample_aggregation_hash_log_assert.svh
// Assertion macros for the sample aggregation block. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_AGGREGATION_HASH_LOG_ASSERT_SVH
`define SAMPLE_AGGREGATION_HASH_LOG_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SAHL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SAHL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAHL_ASSERT_IMP(lbl, ante, cons, msg)
`define SAHL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/sahl_pkg.sv */
// ----------------------------------------------------------------------------
// sahl_pkg
// Codes, transaction types and the bucket hash of the sample aggregation block.
// ----------------------------------------------------------------------------
package sahl_pkg;

  localparam int unsigned TRACE_FIELDS = 4;
  localparam int unsigned CAP_W        = 21;
  localparam int unsigned SLOT_W       = 20;
  localparam int unsigned FLUSH_W      = 12;
  localparam int unsigned MAX_HASH_W   = 16;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_FLUSH  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [2:0] ST_MERGED     = 3'd0;
  localparam logic [2:0] ST_INSERTED   = 3'd1;
  localparam logic [2:0] ST_EVICTED    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_FLUSHED    = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;
  localparam logic [2:0] ST_FLUSH_FAIL = 3'd6;
  localparam logic [2:0] ST_CLEARED    = 3'd7;

  typedef struct packed {
    logic [1:0]                        kind;
    logic [63:0]                       sample_ip;
    logic                              sample_idle;
    logic [TRACE_FIELDS-1:0][63:0]     trace;
    logic [FLUSH_W-1:0]                flush_bucket;
  } item_t;

  typedef struct packed {
    logic [2:0]                        status;
    logic [SLOT_W-1:0]                 log_slot;
    logic [63:0]                       ip;
    logic                              idle;
    logic [TRACE_FIELDS-1:0][63:0]     trace;
    logic [31:0]                       count;
  } result_t;

  // ip ^ idle ^ first depth trace addresses
  function automatic logic [63:0] sahl_hash(item_t it, int unsigned depth);
    logic [63:0] h;
    h = it.sample_ip ^ {63'd0, it.sample_idle};
    for (int unsigned i = 0; i < TRACE_FIELDS; i++) begin
      if (i < depth) h = h ^ it.trace[i];
    end
    return h;
  endfunction

endpackage

/* rtl/sahl_if.sv */
// ----------------------------------------------------------------------------
// sahl_in_if / sahl_out_if
// Valid/ready channels for sample transactions and result transactions.
// ----------------------------------------------------------------------------
interface sahl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] sample_ip;
  logic        sample_idle;
  logic [63:0] trace_0;
  logic [63:0] trace_1;
  logic [63:0] trace_2;
  logic [63:0] trace_3;
  logic [11:0] flush_bucket;

  modport source (output valid, kind, sample_ip, sample_idle, trace_0, trace_1,
                  trace_2, trace_3, flush_bucket, input ready);
  modport sink   (input valid, kind, sample_ip, sample_idle, trace_0, trace_1,
                  trace_2, trace_3, flush_bucket, output ready);
endinterface

interface sahl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [19:0] log_slot;
  logic [63:0] out_ip;
  logic        out_idle;
  logic [63:0] out_trace_0;
  logic [63:0] out_trace_1;
  logic [63:0] out_trace_2;
  logic [63:0] out_trace_3;
  logic [31:0] out_count;

  modport source (output valid, status, log_slot, out_ip, out_idle, out_trace_0,
                  out_trace_1, out_trace_2, out_trace_3, out_count, input ready);
  modport sink   (input valid, status, log_slot, out_ip, out_idle, out_trace_0,
                  out_trace_1, out_trace_2, out_trace_3, out_count, output ready);
endinterface

/* rtl/sample_aggregation_hash_log.sv */
// ----------------------------------------------------------------------------
// sample_aggregation_hash_log
// Direct-mapped profiling sample table with eviction to an external log.
// ----------------------------------------------------------------------------
// Each transaction has two steps: the accept edge issues the bucket read, and
// the commit edge, once the registered read has returned and no earlier result
// blocks the output register, compares, writes the bucket back and loads the
// result register. A new transaction is taken in the cycle after that, while
// an earlier result may still wait on the output. After reset a clearing pass
// writes all 2^HASH_BITS buckets (4096 by default) invalid, one per cycle; no
// input is taken during it, configuration writes are taken at any time.
`include "sample_aggregation_hash_log_assert.svh"

module sample_aggregation_hash_log import sahl_pkg::*; #(
  parameter int unsigned HASH_BITS   = 12,
  parameter int unsigned TRACE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  sahl_in_if.sink          in_ch,
  sahl_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int unsigned ENTRY_W = 1 + 64 + 1 + 64 * TRACE_DEPTH + 32;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [HASH_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HASH_BITS-1:0] addr_r;
  item_t                item_r;
  logic [CAP_W-1:0]     cap_r;
  logic [CAP_W-1:0]     log_fill_r;
  logic                 out_valid_r;
  result_t              result_r;

  item_t                in_item;
  logic [63:0]          hash;
  logic [MAX_HASH_W-1:0] fb_ext;
  logic [HASH_BITS-1:0] in_addr;
  logic                 accept;
  logic                 commit;

  logic                 mem_wr_en;
  logic [HASH_BITS-1:0] mem_wr_addr;
  logic [ENTRY_W-1:0]   mem_wr_data;
  logic [ENTRY_W-1:0]   rd_entry;

  result_t              ev_res;
  logic                 ev_wr_en;
  logic [ENTRY_W-1:0]   ev_wr_entry;
  logic [CAP_W-1:0]     ev_fill_nxt;

  always_comb begin
    in_item.kind         = in_ch.kind;
    in_item.sample_ip    = in_ch.sample_ip;
    in_item.sample_idle  = in_ch.sample_idle;
    in_item.trace[0]     = in_ch.trace_0;
    in_item.trace[1]     = in_ch.trace_1;
    in_item.trace[2]     = in_ch.trace_2;
    in_item.trace[3]     = in_ch.trace_3;
    in_item.flush_bucket = in_ch.flush_bucket;
  end

  assign hash    = sahl_hash(in_item, TRACE_DEPTH);
  assign fb_ext  = MAX_HASH_W'(in_ch.flush_bucket);
  assign in_addr = (in_ch.kind == KIND_RECORD) ? hash[HASH_BITS-1:0]
                                               : fb_ext[HASH_BITS-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == S_RD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + HASH_BITS'(1);
        if (clr_cnt_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_RD;
      end
      S_RD: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      addr_r <= in_addr;
    end
  end

  always_comb begin
    if (state_r == S_CLR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = commit && ev_wr_en;
      mem_wr_addr = addr_r;
      mem_wr_data = ev_wr_entry;
    end
  end

  sahl_mem #(
    .ADDR_W (HASH_BITS),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_entry)
  );

  sahl_eval #(
    .HASH_BITS   (HASH_BITS),
    .TRACE_DEPTH (TRACE_DEPTH)
  ) u_eval (
    .item         (item_r),
    .rd_entry     (rd_entry),
    .log_fill     (log_fill_r),
    .log_capacity (cap_r),
    .res          (ev_res),
    .wr_en        (ev_wr_en),
    .wr_entry     (ev_wr_entry),
    .log_fill_nxt (ev_fill_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_W'(16384);
      log_fill_r <= '0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (commit) log_fill_r <= ev_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) result_r <= ev_res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = result_r.status;
  assign out_ch.log_slot    = result_r.log_slot;
  assign out_ch.out_ip      = result_r.ip;
  assign out_ch.out_idle    = result_r.idle;
  assign out_ch.out_trace_0 = result_r.trace[0];
  assign out_ch.out_trace_1 = result_r.trace[1];
  assign out_ch.out_trace_2 = result_r.trace[2];
  assign out_ch.out_trace_3 = result_r.trace[3];
  assign out_ch.out_count   = result_r.count;

  `SAHL_ASSERT_NXT(a_accept_reads, accept, state_r == S_RD, "accepted transaction not in read stage")
  `SAHL_ASSERT_IMP(a_clear_blocks, state_r == S_CLR, !in_ch.ready, "input taken during clear pass")
  `SAHL_ASSERT_NXT(a_commit_shows, commit, out_valid_r, "committed result not presented")
  `SAHL_ASSERT_NXT(a_clear_fill, commit && (item_r.kind == KIND_CLEAR), log_fill_r == '0, "log fill not cleared")

endmodule

/* rtl/sahl_mem.sv */
// ----------------------------------------------------------------------------
// sahl_mem
// Single-port-write, single-port-read bucket table, registered read data.
// ----------------------------------------------------------------------------
module sahl_mem #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 354
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/sahl_eval.sv */
// ----------------------------------------------------------------------------
// sahl_eval
// Bucket update: merge, insert, evict, flush and log fill bookkeeping.
// ----------------------------------------------------------------------------
module sahl_eval import sahl_pkg::*; #(
  parameter int unsigned HASH_BITS   = 12,
  parameter int unsigned TRACE_DEPTH = 4,
  localparam int unsigned ENTRY_W    = 1 + 64 + 1 + 64 * TRACE_DEPTH + 32
) (
  input  item_t              item,
  input  logic [ENTRY_W-1:0] rd_entry,
  input  logic [CAP_W-1:0]   log_fill,
  input  logic [CAP_W-1:0]   log_capacity,
  output result_t            res,
  output logic               wr_en,
  output logic [ENTRY_W-1:0] wr_entry,
  output logic [CAP_W-1:0]   log_fill_nxt
);

  typedef struct packed {
    logic                         valid;
    logic [63:0]                  ip;
    logic                         idle;
    logic [TRACE_DEPTH-1:0][63:0] trace;
    logic [31:0]                  hits;
  } entry_t;

  localparam logic [CAP_W:0] RESERVE = (CAP_W + 1)'(1) << HASH_BITS;

  entry_t                        ent;
  entry_t                        nent;
  entry_t                        went;
  logic [TRACE_DEPTH-1:0][63:0]  tr_in;
  logic [TRACE_FIELDS-1:0][63:0] shown;
  logic                          same;
  logic                          rec_full;
  logic                          flush_full;

  assign ent = entry_t'(rd_entry);

  for (genvar g = 0; g < TRACE_DEPTH; g++) begin : g_tr_in
    if (g < TRACE_FIELDS) begin : g_used
      assign tr_in[g] = item.trace[g];
    end else begin : g_zero
      assign tr_in[g] = '0;
    end
  end

  for (genvar g = 0; g < TRACE_FIELDS; g++) begin : g_shown
    if (g < TRACE_DEPTH) begin : g_used
      assign shown[g] = ent.trace[g];
    end else begin : g_zero
      assign shown[g] = '0;
    end
  end

  assign same = ent.valid && (ent.ip == item.sample_ip) &&
                (ent.idle == item.sample_idle) && (ent.trace == tr_in);

  assign rec_full   = ({1'b0, log_fill} + RESERVE) >= {1'b0, log_capacity};
  assign flush_full = log_fill >= log_capacity;

  always_comb begin
    nent.valid = 1'b1;
    nent.ip    = item.sample_ip;
    nent.idle  = item.sample_idle;
    nent.trace = tr_in;
    nent.hits  = 32'd1;
  end

  always_comb begin
    res          = '0;
    wr_en        = 1'b0;
    went         = ent;
    log_fill_nxt = log_fill;
    case (item.kind)
      KIND_RECORD: begin
        if (same) begin
          wr_en      = 1'b1;
          if (ent.hits != '1) went.hits = ent.hits + 32'd1;
          res.status = ST_MERGED;
        end else if (ent.valid) begin
          if (rec_full) begin
            res.status = ST_FULL;
          end else begin
            res.status   = ST_EVICTED;
            res.log_slot = log_fill[SLOT_W-1:0];
            res.ip       = ent.ip;
            res.idle     = ent.idle;
            res.trace    = shown;
            res.count    = ent.hits;
            log_fill_nxt = log_fill + CAP_W'(1);
            wr_en        = 1'b1;
            went         = nent;
          end
        end else begin
          res.status = ST_INSERTED;
          wr_en      = 1'b1;
          went       = nent;
        end
      end
      KIND_FLUSH: begin
        if (!ent.valid) begin
          res.status = ST_EMPTY;
        end else begin
          wr_en      = 1'b1;
          went.valid = 1'b0;
          res.ip     = ent.ip;
          res.idle   = ent.idle;
          res.trace  = shown;
          res.count  = ent.hits;
          if (flush_full) begin
            res.status = ST_FLUSH_FAIL;
          end else begin
            res.status   = ST_FLUSHED;
            res.log_slot = log_fill[SLOT_W-1:0];
            log_fill_nxt = log_fill + CAP_W'(1);
          end
        end
      end
      KIND_CLEAR: begin
        log_fill_nxt = '0;
        res.status   = ST_CLEARED;
      end
      default: begin
        res.status = ST_EMPTY;
      end
    endcase
  end

  assign wr_entry = ENTRY_W'(went);

endmodule
